// ===== design/inverse_trig_series_top_assert.svh =====
// Assertion macros for the inverse trig block
`ifndef INVERSE_TRIG_SERIES_TOP_ASSERT_SVH
`define INVERSE_TRIG_SERIES_TOP_ASSERT_SVH
// a implies b on the next edge
`define ITS_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("label failed");
// a implies b on the same edge
`define ITS_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("label failed");
`endif

// ===== design/its_pkg.sv =====
`timescale 1ns / 1ps
package its_pkg;
  localparam int MAX_TERMS = 256;
  localparam int NW = $clog2(MAX_TERMS + 1);
  localparam logic [31:0] HALF_PI = 32'd421657428;
  localparam logic [31:0] QUARTER_PI = 32'd210828714;
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [1:0] ACT_ASIN = 2'd0;
  localparam logic [1:0] ACT_ACOS = 2'd1;
  localparam logic [1:0] ACT_ATAN = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;
  // shared divider jobs
  localparam logic [1:0] DIV_RATIO = 2'd0;
  localparam logic [1:0] DIV_TERM = 2'd1;
  localparam logic [1:0] DIV_RECIP = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic signed [31:0] x;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic invalid;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RECIP, S_SQ, S_TEST, S_MUL, S_SCALE, S_RAT, S_DIVD, S_FIN, S_OUT
  } state_t;
endpackage

// ===== design/inverse_trig_series_top.sv =====
`timescale 1ns / 1ps
// Inverse trig (asin / acos / atan) by series in fixed point.
// Input word: action (0 asin, 1 acos, 2 atan) and x, signed Q8.24, on
// in_valid / in_ready. Output word: angle, signed Q3.28, and invalid, on
// out_valid / out_ready. One word in flight at a time: in_ready is high only
// while idle and no result is held.
// From the input handshake to out_valid the steps are square, last test,
// finish and output, plus per series term, for asin/acos: multiply, scale
// by 2n-1, ratio divide by 2n, divide by 2n+1, test; for atan: multiply,
// divide by 2n+1, test; up to MAX_TERMS-1 terms. atan with |x|>1 adds a
// reciprocal divide up front. |x| exactly one goes straight to output,
// invalid words through finish and output.
// All divides go through one shared shift/subtract unit, one quotient bit
// per cycle; one shared multiplier does the square, the term and the scale.
// thr (term threshold) is written by cfg_we/cfg_data, reset value 4.
// The user must write it only while idle; the block does not enforce it.
// Reset empties the block and drops any pending result. While the receiver
// stalls the result is held and no new word is taken; the next word is taken
// the cycle after the result is accepted.
module inverse_trig_series_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  its_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output its_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [20:0] cfg_data
);
  its_pkg::state_t state, state_next;
  logic [20:0] thr;
  logic [1:0] act;
  logic neg, big, atn;
  logic [27:0] m, s;
  logic [28:0] t;
  logic signed [34:0] sum;
  logic [its_pkg::NW-1:0] n;
  logic [1:0] divsel;
  // shared divider: dividend shifted out of dq, remainder in rem
  logic [52:0] dq;
  logic [33:0] rem, dv;
  logic [5:0] cnt;
  logic [33:0] trial;
  logic [52:0] quo;
  // shared multiplier
  logic [28:0] mul_a;
  logic [27:0] mul_b;
  logic [61:0] prod;
  logic [28:0] tn;
  logic [31:0] in_mag;
  logic signed [31:0] unit_angle;
  logic signed [34:0] fin;

  assign trial = {rem[32:0], dq[52]};
  assign quo = {dq[51:0], trial >= dv};
  assign mul_a = (state == its_pkg::S_SQ) ? {1'b0, m} : t;
  assign mul_b = (state == its_pkg::S_SQ) ? m :
                 (state == its_pkg::S_SCALE) ? 28'({n, 1'b0} - 1'b1) : s;
  assign prod = 62'(mul_a) * 62'(mul_b);
  assign tn = 29'(prod >> 28);
  assign in_mag = in_data.x[31] ? 32'(-in_data.x) : 32'(in_data.x);
  assign in_ready = (state == its_pkg::S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      its_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.action == its_pkg::ACT_NONE) state_next = its_pkg::S_FIN;
          else if (in_mag == its_pkg::ONE_Q24) state_next = its_pkg::S_OUT;
          else if (in_mag < its_pkg::ONE_Q24) state_next = its_pkg::S_SQ;
          else if (in_data.action == its_pkg::ACT_ATAN) state_next = its_pkg::S_RECIP;
          else state_next = its_pkg::S_FIN;
        end
      end
      its_pkg::S_RECIP: if (cnt == 6'd0) state_next = its_pkg::S_SQ;
      its_pkg::S_SQ: state_next = its_pkg::S_TEST;
      its_pkg::S_TEST: begin
        if (n < its_pkg::NW'(its_pkg::MAX_TERMS) && t >= 29'(thr))
          state_next = its_pkg::S_MUL;
        else state_next = its_pkg::S_FIN;
      end
      its_pkg::S_MUL: state_next = atn ? its_pkg::S_DIVD : its_pkg::S_SCALE;
      its_pkg::S_SCALE: state_next = its_pkg::S_RAT;
      its_pkg::S_RAT: if (cnt == 6'd0) state_next = its_pkg::S_DIVD;
      its_pkg::S_DIVD: if (cnt == 6'd0) state_next = its_pkg::S_TEST;
      its_pkg::S_FIN: state_next = its_pkg::S_OUT;
      its_pkg::S_OUT: state_next = its_pkg::S_IDLE;
      default: state_next = its_pkg::S_IDLE;
    endcase
  end

  // angle for |x| exactly one
  always_comb begin
    case (in_data.action)
      its_pkg::ACT_ASIN:
        unit_angle = in_data.x[31] ? -$signed(its_pkg::HALF_PI) : $signed(its_pkg::HALF_PI);
      its_pkg::ACT_ACOS:
        unit_angle = in_data.x[31] ? $signed(its_pkg::HALF_PI << 1) : 32'sd0;
      its_pkg::ACT_ATAN:
        unit_angle = in_data.x[31] ? -$signed(its_pkg::QUARTER_PI)
                                   : $signed(its_pkg::QUARTER_PI);
      default: unit_angle = 32'sd0;
    endcase
  end

  // final angle from the series sum
  always_comb begin
    fin = 35'sd0;
    if (atn) begin
      if (big) fin = $signed({3'd0, its_pkg::HALF_PI}) - sum;
      else fin = sum;
      if (neg) fin = -fin;
    end else begin
      fin = neg ? -sum : sum;
      if (act == its_pkg::ACT_ACOS) fin = $signed({3'd0, its_pkg::HALF_PI}) - fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= its_pkg::S_IDLE;
      out_valid <= 1'b0;
      thr <= 21'd4;
    end else begin
      state <= state_next;
      if (cfg_we) thr <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        its_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            act <= in_data.action;
            neg <= in_data.x[31];
            atn <= in_data.action == its_pkg::ACT_ATAN;
            big <= in_data.action == its_pkg::ACT_ATAN && in_mag > its_pkg::ONE_Q24;
            n <= its_pkg::NW'(1);
            m <= {in_mag[23:0], 4'd0};
            t <= {1'b0, in_mag[23:0], 4'd0};
            sum <= 35'({in_mag[23:0], 4'd0});
            // reciprocal 2^52 / |x|, only run for atan with |x| > 1
            dq <= {1'b1, 52'd0};
            rem <= 34'd0;
            dv <= 34'(in_mag);
            cnt <= 6'd52;
            divsel <= its_pkg::DIV_RECIP;
            out_data.invalid <= in_data.action == its_pkg::ACT_NONE ||
              (in_mag > its_pkg::ONE_Q24 && in_data.action != its_pkg::ACT_ATAN);
            out_data.angle <= (in_mag == its_pkg::ONE_Q24) ? unit_angle : 32'sd0;
          end
        end
        its_pkg::S_RECIP, its_pkg::S_RAT, its_pkg::S_DIVD: begin
          if (cnt != 6'd0) begin
            rem <= (trial >= dv) ? trial - dv : trial;
            dq <= quo;
            cnt <= cnt - 6'd1;
          end else if (divsel == its_pkg::DIV_RECIP) begin
            m <= 28'(quo);
            t <= 29'(quo);
            sum <= 35'(quo);
          end else if (divsel == its_pkg::DIV_RATIO) begin
            t <= 29'(quo);
            dq <= {4'd0, 29'(quo), 20'd0};
            rem <= 34'd0;
            dv <= 34'({n, 1'b1});
            cnt <= 6'd32;
            divsel <= its_pkg::DIV_TERM;
          end else begin
            if (atn && n[0]) sum <= sum - 35'(quo);
            else sum <= sum + 35'(quo);
            n <= n + its_pkg::NW'(1);
          end
        end
        its_pkg::S_SQ: s <= 28'(prod >> 28);
        its_pkg::S_MUL: begin
          t <= tn;
          if (atn) begin
            dq <= {4'd0, tn, 20'd0};
            rem <= 34'd0;
            dv <= 34'({n, 1'b1});
            cnt <= 6'd32;
            divsel <= its_pkg::DIV_TERM;
          end
        end
        // t * (2n-1), 37 bits, then divided by 2n
        its_pkg::S_SCALE: begin
          dq <= {prod[36:0], 16'd0};
          rem <= 34'd0;
          dv <= 34'({n, 1'b0});
          cnt <= 6'd36;
          divsel <= its_pkg::DIV_RATIO;
        end
        its_pkg::S_FIN: if (!out_data.invalid) out_data.angle <= 32'(fin);
        its_pkg::S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== design/its_checker.sv =====
`timescale 1ns / 1ps
`include "inverse_trig_series_top_assert.svh"
module its_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input its_pkg::out_word_t out_data
);
  `ITS_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ITS_NOW(a_busy, out_valid, !in_ready)
  `ITS_NEXT(a_nodup, in_valid && in_ready, !out_valid)
endmodule

bind inverse_trig_series_top its_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
